>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked concurrent assertions that are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge of clk_i outside reset.
`define BF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// An implication that is checked in the same cycle.
`define BF_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define BF_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/bf3h_pkg.sv
// ----------------------------------------------------------------------------
// bf3h_pkg
// Types and constants of the three-hash Bloom filter unit.
// ----------------------------------------------------------------------------
package bf3h_pkg;

  // Default depth of the filter bit store.
  localparam int unsigned MAX_BITS_DEF = 4096;

  // Fixed field widths.
  localparam int unsigned KEY_W = 31;
  localparam int unsigned CFG_W = 13;
  localparam int unsigned CNT_W = 5;

  // Table size after reset.
  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 13'd4096;

  // Hash multipliers 0.21 and 0.67 as Q0.32 fractions, rounded to nearest.
  localparam logic [31:0] COEF_A = 32'd901943132;
  localparam logic [31:0] COEF_B = 32'd2877628088;

  // Operation carried in tuser.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MA,
    S_MAM,
    S_MB,
    S_MBM,
    S_IDX3,
    S_DIV,
    S_PROBE,
    S_DONE
  } state_e;

endpackage

>>> hdl/bloom_filter_three_hash_unit.sv
// Flow: a query answer shows on the master side in the same cycle in which the unit is
// ready again for the next word. An insert gives no word. The unit takes a new word only
// when it is through with the last one: it runs the bit-serial remainder loop, four passes
// through the shared multiplier and one store access a cycle; a query waits longer while
// the previous answer is not taken.
// Reset: asynchronous, active low; table_size returns to 4096 and the bit store is cleared.
// ----------------------------------------------------------------------------
// bloom_filter_three_hash_unit
// Bloom filter with three hashes over a single-bit store, run by a small
// sequencer around one shared multiplier and one shared subtractor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bloom_filter_three_hash_unit #(
  parameter int unsigned MAX_BITS = bf3h_pkg::MAX_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration: table_size.
  input  logic                       cfg_we_i,
  input  logic [bf3h_pkg::CFG_W-1:0] cfg_wdata_i,
  // Slave side.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // [30:0] key, [31] zero
  input  logic [0:0]                 s_axis_tuser,  // [0] opcode
  // Master side.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata   // [0] maybe_present, [7:1] zero
);
  import bf3h_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BITS);
  localparam int unsigned MW = $clog2(MAX_BITS + 1);
  localparam int unsigned RW = MW + 1;

  // Control state.
  state_e             state_q, state_d;
  logic [CFG_W-1:0]   table_size_q;
  logic [AW-1:0]      clr_addr_q, clr_addr_d;
  logic [CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic [1:0]         probe_cnt_q, probe_cnt_d;
  logic               out_valid_q, out_valid_d;

  // Working registers.
  op_e                op_q, op_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [MW-1:0]      m_q, m_d;
  logic [RW-1:0]      rem_q, rem_d;
  logic [AW-1:0]      idx2_q, idx2_d;
  logic [AW-1:0]      idx3_q, idx3_d;
  logic               hit_q, hit_d;
  logic               out_data_q, out_data_d;
  logic [63:0]        prod_q;

  // Shared units.
  logic [31:0]        mul_a, mul_b;
  logic [RW-1:0]      rem_sh;
  logic [RW:0]        rem_diff;
  logic [31:0]        ts_wide;

  // Bit store.
  logic               mem [MAX_BITS];
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic               mem_wdata;
  logic               rd_q;

  logic               in_acc;
  logic               out_load;

  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_data_q};

  // Effective modulus: zero counts as one, large sizes saturate at the store depth.
  assign ts_wide = 32'(table_size_q);

  // One restoring-division step: shift in the next key bit, subtract if it fits.
  assign rem_sh   = {rem_q[RW-2:0], key_q[KEY_W-1]};
  assign rem_diff = {1'b0, rem_sh} - (RW+1)'(m_q);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TABLE_SIZE_RST;
    end else if (cfg_we_i) begin
      table_size_q <= cfg_wdata_i;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      div_cnt_q   <= '0;
      probe_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      div_cnt_q   <= div_cnt_d;
      probe_cnt_q <= probe_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    m_q        <= m_d;
    rem_q      <= rem_d;
    idx2_q     <= idx2_d;
    idx3_q     <= idx3_d;
    hit_q      <= hit_d;
    out_data_q <= out_data_d;
    prod_q     <= 64'(mul_a) * 64'(mul_b);
  end

  // Bit store with one address port and registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_q <= mem[mem_addr];
  end

  // Sequencer: next state, datapath controls and the output register.
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    div_cnt_d   = div_cnt_q;
    probe_cnt_d = probe_cnt_q;
    op_d        = op_q;
    key_d       = key_q;
    m_d         = m_q;
    rem_d       = rem_q;
    idx2_d      = idx2_q;
    idx3_d      = idx3_q;
    hit_d       = hit_q;
    out_data_d  = out_data_q;
    mul_a       = {1'b0, key_q};
    mul_b       = COEF_A;
    mem_we      = 1'b0;
    mem_wdata   = 1'b0;
    s_axis_tready = 1'b0;
    out_load    = 1'b0;

    // Probe address follows the probe counter.
    unique case (probe_cnt_q)
      2'd0:    mem_addr = rem_q[AW-1:0];
      2'd1:    mem_addr = idx2_q;
      2'd2:    mem_addr = idx3_q;
      default: mem_addr = rem_q[AW-1:0];
    endcase

    unique case (state_q)
      S_CLEAR: begin
        mem_addr   = clr_addr_q;
        mem_we     = 1'b1;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(MAX_BITS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d  = op_e'(s_axis_tuser[0]);
          key_d = s_axis_tdata[KEY_W-1:0];
          hit_d = 1'b1;
          if (ts_wide == 32'd0) begin
            m_d = MW'(1);
          end else if (ts_wide > 32'(MAX_BITS)) begin
            m_d = MW'(MAX_BITS);
          end else begin
            m_d = MW'(ts_wide);
          end
          state_d = S_MA;
        end
      end
      // Fraction of key * 0.21.
      S_MA: begin
        mul_a   = {1'b0, key_q};
        mul_b   = COEF_A;
        state_d = S_MAM;
      end
      // Scale the fraction by the modulus.
      S_MAM: begin
        mul_a   = prod_q[31:0];
        mul_b   = 32'(m_q);
        state_d = S_MB;
      end
      // Keep the second index, start key * 0.67.
      S_MB: begin
        idx2_d  = prod_q[32 +: AW];
        mul_a   = {1'b0, key_q};
        mul_b   = COEF_B;
        state_d = S_MBM;
      end
      S_MBM: begin
        mul_a   = prod_q[31:0];
        mul_b   = 32'(m_q);
        state_d = S_IDX3;
      end
      // Keep the third index and set up the remainder loop.
      S_IDX3: begin
        idx3_d    = prod_q[32 +: AW];
        rem_d     = '0;
        div_cnt_d = CNT_W'(KEY_W - 1);
        state_d   = S_DIV;
      end
      // Key mod m, one key bit a cycle.
      S_DIV: begin
        rem_d = rem_diff[RW] ? rem_sh : rem_diff[RW-1:0];
        key_d = {key_q[KEY_W-2:0], 1'b0};
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          probe_cnt_d = '0;
          state_d     = S_PROBE;
        end
      end
      // Three store accesses: writes for an insert, reads for a query.
      S_PROBE: begin
        probe_cnt_d = probe_cnt_q + 1'b1;
        if (op_q == OP_INSERT) begin
          mem_we    = 1'b1;
          mem_wdata = 1'b1;
          if (probe_cnt_q == 2'd2) begin
            state_d = S_IDLE;
          end
        end else begin
          if (probe_cnt_q != 2'd0) begin
            hit_d = hit_q & rd_q;
          end
          if (probe_cnt_q == 2'd3) begin
            state_d = S_DONE;
          end
        end
      end
      // Hand the answer to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load   = 1'b1;
          out_data_d = hit_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_load | (out_valid_q & ~m_axis_tready);
  end

  // Checks.
  `BF_ASSERT_NXT(a_busy_after_accept, in_acc, !s_axis_tready, "ready after an accepted word")
  `BF_ASSERT_IMP(a_index_in_range, state_q == S_PROBE, MW'(mem_addr) < m_q, "probe index high")
  `BF_ASSERT_IMP(a_result_from_query, $rose(out_valid_q), op_q == OP_QUERY, "result for insert")
  `BF_ASSERT_IMP(a_no_accept_in_clear, state_q == S_CLEAR, !s_axis_tready, "ready while clearing")

endmodule
